// ----- design/sdp_pkg.sv -----
// Shared types, codes and constants for the SD card SPI-mode type probe.
// No dependencies; used by the probe FSM and the top level.
package sdp_pkg;

	// Input command codes
	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_RX    = 2'd1,
		CMD_TICK  = 2'd2
	} command_t;

	// Result card type codes
	typedef enum logic [2:0] {
		TYPE_UNKNOWN = 3'd0,
		TYPE_SD1     = 3'd1,
		TYPE_SD2     = 3'd2,
		TYPE_ERROR   = 3'd3,
		TYPE_TIMEOUT = 3'd4
	} card_type_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_PREAMBLE = 3'd1,
		PH_WAIT     = 3'd2,
		PH_FRAME    = 3'd3,
		PH_POLL     = 3'd4,
		PH_TAIL     = 3'd5
	} phase_t;

	// Configuration register indexes
	typedef enum logic {
		CFG_BUSY_WAIT    = 1'b0,
		CFG_INIT_TIMEOUT = 1'b1
	} cfg_index_t;

	localparam logic [15:0] BUSY_WAIT_RESET    = 16'd300;
	localparam logic [15:0] INIT_TIMEOUT_RESET = 16'd1000;

	localparam logic [7:0]  IDLE_BYTE      = 8'hFF;
	localparam logic [7:0]  STATUS_IDLE    = 8'h01;
	localparam logic [7:0]  CHECK_PATTERN  = 8'hAA;
	localparam int unsigned ILLEGAL_CMD_BIT = 2;
	localparam logic [15:0] TICK_MAX       = 16'hFFFF;
	localparam int unsigned FRAME_LAST     = 5;
	localparam int unsigned TAIL_BYTES     = 4;

	// One result item plus its presence flag
	typedef struct packed {
		logic       present;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       chip_select;
		logic       done_res;
		card_type_t card_type;
	} result_t;

	// Command frame: CMD0 (0x40, arg 0, CRC 0x95) or CMD8 (0x48, arg 0x1AA, CRC 0x87)
	function automatic logic [7:0] frame_byte(input logic cmd8, input logic [2:0] k);
		logic [7:0] b;
		begin
			unique case (k)
				3'd0:    b = cmd8 ? 8'h48 : 8'h40;
				3'd3:    b = cmd8 ? 8'h01 : 8'h00;
				3'd4:    b = cmd8 ? 8'hAA : 8'h00;
				3'd5:    b = cmd8 ? 8'h87 : 8'h95;
				default: b = 8'h00;
			endcase
			return b;
		end
	endfunction

endpackage

// ----- design/sdp_in_if.sv -----
// Input channel of the SD card type probe: command and received byte.
// Depends on nothing beyond its own fields.
interface sdp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink (input valid, input command, input rx_byte, output ready);
endinterface

// ----- design/sdp_out_if.sv -----
// Result channel of the SD card type probe: byte to send, select and status.
// Depends on nothing beyond its own fields.
interface sdp_out_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       chip_select;
	logic       done_res;
	logic [2:0] card_type;

	modport source (output valid, output tx_valid, output tx_byte, output chip_select,
		output done_res, output card_type, input ready);
	modport sink (input valid, input tx_valid, input tx_byte, input chip_select,
		input done_res, input card_type, output ready);
endinterface

// ----- design/sd_spi_card_type_probe_top.sv -----
// SD card type probe, SPI mode: input register, probe FSM, result register.
// Depends on sdp_pkg, sdp_in_if, sdp_out_if and sdp_fsm.
//
// Each item (start, received byte or timer tick) is taken into an input
// register, processed by the probe FSM and, if it causes a result, placed
// in the result register: one item per cycle when no stall holds the flow.
// The result register stalls the input register only while a result waits
// and the sink is not ready. Every result with tx_valid set expects
// exactly one received-byte item back; a final result carries done_res
// and card_type.
module sd_spi_card_type_probe_top #(
	parameter int unsigned PREAMBLE_BYTES = 10,
	parameter int unsigned RESPONSE_POLLS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	sdp_in_if.sink      req,
	sdp_out_if.source   rsp
);
	logic [15:0] busy_wait_q, init_timeout_q;

	logic       valid_s1;
	logic [1:0] command_s1;
	logic [7:0] rx_byte_s1;

	logic       out_valid_q;
	logic       out_tx_valid_q;
	logic [7:0] out_tx_byte_q;
	logic       out_cs_q;
	logic       out_done_q;
	logic [2:0] out_type_q;

	logic             out_free;
	logic             advance;
	sdp_pkg::result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_wait_q    <= sdp_pkg::BUSY_WAIT_RESET;
			init_timeout_q <= sdp_pkg::INIT_TIMEOUT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == sdp_pkg::CFG_BUSY_WAIT) busy_wait_q <= cfg_wdata;
			else init_timeout_q <= cfg_wdata;
		end
	end

	assign out_free  = !out_valid_q || rsp.ready;
	assign advance   = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			command_s1 <= req.command;
			rx_byte_s1 <= req.rx_byte;
		end
	end

	sdp_fsm #(
		.PREAMBLE_BYTES (PREAMBLE_BYTES),
		.RESPONSE_POLLS (RESPONSE_POLLS)
	) u_fsm (
		.clk                (clk),
		.arst_n             (arst_n),
		.step               (advance),
		.command            (command_s1),
		.rx_byte            (rx_byte_s1),
		.busy_wait_ticks    (busy_wait_q),
		.init_timeout_ticks (init_timeout_q),
		.result             (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && result.present) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.present) begin
			out_tx_valid_q <= result.tx_valid;
			out_tx_byte_q  <= result.tx_byte;
			out_cs_q       <= result.chip_select;
			out_done_q     <= result.done_res;
			out_type_q     <= result.card_type;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.tx_valid    = out_tx_valid_q;
	assign rsp.tx_byte     = out_tx_byte_q;
	assign rsp.chip_select = out_cs_q;
	assign rsp.done_res    = out_done_q;
	assign rsp.card_type   = out_type_q;

endmodule

// ----- design/sdp_fsm.sv -----
// Probe state machine: phase, byte counter and tick counters, one step per item.
// Depends on sdp_pkg.
module sdp_fsm #(
	parameter int unsigned PREAMBLE_BYTES = 10,
	parameter int unsigned RESPONSE_POLLS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [1:0]          command,
	input  logic [7:0]          rx_byte,
	input  logic [15:0]         busy_wait_ticks,
	input  logic [15:0]         init_timeout_ticks,
	output sdp_pkg::result_t    result
);
	localparam int unsigned CNT_MAX = (PREAMBLE_BYTES > RESPONSE_POLLS) ?
		PREAMBLE_BYTES : RESPONSE_POLLS;
	localparam int unsigned CNT_W = $clog2(CNT_MAX + 1);

	sdp_pkg::phase_t phase_q, phase_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             cmd8_q, cmd8_d;
	logic [15:0]      init_q, init_d;
	logic [15:0]      wait_q, wait_d;

	logic [CNT_W-1:0] count_inc;
	logic [7:0]       status;
	logic             resp_seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdp_pkg::PH_IDLE;
			count_q <= '0;
			cmd8_q  <= 1'b0;
			init_q  <= '0;
			wait_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			cmd8_q  <= cmd8_d;
			init_q  <= init_d;
			wait_q  <= wait_d;
		end
	end

	assign count_inc = count_q + CNT_W'(1);
	assign resp_seen = !rx_byte[7] || (count_inc >= CNT_W'(RESPONSE_POLLS));
	assign status    = rx_byte[7] ? sdp_pkg::IDLE_BYTE : rx_byte;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		cmd8_d  = cmd8_q;
		init_d  = init_q;
		wait_d  = wait_q;

		result.present     = 1'b0;
		result.tx_valid    = 1'b1;
		result.tx_byte     = sdp_pkg::IDLE_BYTE;
		result.chip_select = 1'b1;
		result.done_res    = 1'b0;
		result.card_type   = sdp_pkg::TYPE_UNKNOWN;

		unique case (command)
			sdp_pkg::CMD_START: begin
				if (phase_q == sdp_pkg::PH_IDLE) begin
					phase_d = sdp_pkg::PH_PREAMBLE;
					count_d = '0;
					cmd8_d  = 1'b0;
					init_d  = '0;
					wait_d  = '0;
					result.present     = 1'b1;
					result.chip_select = 1'b0;
				end
			end
			sdp_pkg::CMD_TICK: begin
				if (phase_q != sdp_pkg::PH_IDLE) begin
					if (init_q != sdp_pkg::TICK_MAX) init_d = init_q + 16'd1;
					if (wait_q != sdp_pkg::TICK_MAX) wait_d = wait_q + 16'd1;
				end
			end
			sdp_pkg::CMD_RX: begin
				unique case (phase_q)
					sdp_pkg::PH_IDLE: begin
					end
					sdp_pkg::PH_PREAMBLE: begin
						result.present = 1'b1;
						if (count_inc < CNT_W'(PREAMBLE_BYTES)) begin
							count_d = count_inc;
							result.chip_select = 1'b0;
						end else begin
							cmd8_d  = 1'b0;
							init_d  = '0;
							phase_d = sdp_pkg::PH_WAIT;
							wait_d  = '0;
							count_d = '0;
						end
					end
					sdp_pkg::PH_WAIT: begin
						result.present = 1'b1;
						if (rx_byte == sdp_pkg::IDLE_BYTE || wait_q >= busy_wait_ticks) begin
							phase_d = sdp_pkg::PH_FRAME;
							count_d = '0;
							result.tx_byte = sdp_pkg::frame_byte(cmd8_q, 3'd0);
						end
					end
					sdp_pkg::PH_FRAME: begin
						result.present = 1'b1;
						if (count_inc <= CNT_W'(sdp_pkg::FRAME_LAST)) begin
							count_d = count_inc;
							result.tx_byte = sdp_pkg::frame_byte(cmd8_q, count_inc[2:0]);
						end else begin
							phase_d = sdp_pkg::PH_POLL;
							count_d = '0;
						end
					end
					sdp_pkg::PH_POLL: begin
						result.present = 1'b1;
						count_d = count_inc;
						if (resp_seen) begin
							if (!cmd8_q) begin
								if (init_q > init_timeout_ticks) begin
									phase_d = sdp_pkg::PH_IDLE;
									count_d = '0;
									result.tx_valid    = 1'b0;
									result.chip_select = 1'b0;
									result.done_res    = 1'b1;
									result.card_type   = sdp_pkg::TYPE_TIMEOUT;
								end else begin
									if (status == sdp_pkg::STATUS_IDLE) cmd8_d = 1'b1;
									phase_d = sdp_pkg::PH_WAIT;
									wait_d  = '0;
									count_d = '0;
								end
							end else if (status[sdp_pkg::ILLEGAL_CMD_BIT]) begin
								phase_d = sdp_pkg::PH_IDLE;
								count_d = '0;
								result.tx_valid    = 1'b0;
								result.chip_select = 1'b0;
								result.done_res    = 1'b1;
								result.card_type   = sdp_pkg::TYPE_SD1;
							end else begin
								phase_d = sdp_pkg::PH_TAIL;
								count_d = '0;
							end
						end
					end
					sdp_pkg::PH_TAIL: begin
						result.present = 1'b1;
						if (count_inc < CNT_W'(sdp_pkg::TAIL_BYTES)) begin
							count_d = count_inc;
						end else begin
							phase_d = sdp_pkg::PH_IDLE;
							count_d = '0;
							result.tx_valid    = 1'b0;
							result.chip_select = 1'b0;
							result.done_res    = 1'b1;
							result.card_type   = (rx_byte == sdp_pkg::CHECK_PATTERN) ?
								sdp_pkg::TYPE_SD2 : sdp_pkg::TYPE_ERROR;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

endmodule
